// ----- hdl/cil_pkg.sv -----
package cil_pkg;

    localparam int unsigned HDR_BYTES  = 16;
    localparam int unsigned CNT_W      = 17;
    localparam int unsigned ADDR_W     = 16;
    localparam int unsigned NUM_PEND   = 8;
    localparam int unsigned PEND_IDX_W = $clog2(NUM_PEND);
    localparam int unsigned NUM_VEC    = 6;
    localparam int unsigned VEC_IDX_W  = $clog2(NUM_VEC);

    localparam logic [7:0]        START_MARK = 8'h5A;
    localparam logic [7:0]        END_MARK   = 8'hA5;
    localparam logic [7:0]        MAJOR_VER  = 8'h01;
    localparam logic [CNT_W-1:0]  MEM_TOP    = 17'h10000;
    localparam logic [ADDR_W-1:0] VEC_BASE   = 16'hFFFA;

    localparam logic [3:0] IDX_START   = 4'd0;
    localparam logic [3:0] IDX_MAJOR   = 4'd2;
    localparam logic [3:0] IDX_BASE_LO = 4'd3;
    localparam logic [3:0] IDX_BASE_HI = 4'd4;
    localparam logic [3:0] IDX_SIZE_LO = 4'd5;
    localparam logic [3:0] IDX_SIZE_HI = 4'd6;
    localparam logic [3:0] IDX_TYPE    = 4'd7;
    localparam logic [3:0] IDX_VEC0    = 4'd8;
    localparam logic [3:0] IDX_VEC5    = 4'd13;
    localparam logic [3:0] IDX_CSUM    = 4'd14;
    localparam logic [3:0] IDX_END     = 4'd15;

    localparam logic [PEND_IDX_W-1:0] SLOT_WRITE  = 3'd0;
    localparam logic [PEND_IDX_W-1:0] SLOT_STATUS = 3'd7;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DONE    = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_SMALL = 3'd1,
        ST_MARKERS   = 3'd2,
        ST_VERSION   = 3'd3,
        ST_CHECKSUM  = 3'd4,
        ST_NO_FIT    = 3'd5,
        ST_SIZE      = 3'd6
    } t_status;

    typedef enum logic {
        RK_WRITE  = 1'b0,
        RK_STATUS = 1'b1
    } t_kind;

    // keep the lowest nonzero fault code
    function automatic t_status merge_fault(input t_status cur, input t_status code);
        if (cur == ST_OK || code < cur) begin
            return code;
        end
        return cur;
    endfunction

endpackage

// ----- hdl/cartridge_image_loader.sv -----
// Cartridge image loader.
// Configure i_cfg_wdata (image length, header included) with i_cfg_we while
// idle, then stream the image one byte per transfer on the input channel
// (i_in_valid / o_in_stall). The block checks the 16-byte header, turns each
// payload byte into a memory write result, then emits the selected vector
// writes at FFFA..FFFF and a final status result on the output channel
// (o_out_valid / i_out_stall). o_last_of_run marks the last result caused
// by one input byte.
// Latency: results of a byte appear the cycle after its transfer.
// Throughput: one byte per cycle while each byte yields at most one result
// and the receiver does not stall; a byte with more results holds the input
// until its last one leaves, one per cycle. Of the header bytes only the end
// marker and a first byte with a too short length yield results; bytes after
// the end yield none. Reset (synchronous, active low) returns to the header
// phase, clears the count, checksum and fault and drops pending results; the
// length register resets to zero. While the receiver stalls, the current
// result holds and the input stalls as soon as a byte's results are pending.
module cartridge_image_loader
    import cil_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_image_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_result_kind,
    output logic [ADDR_W-1:0] o_write_address,
    output logic [7:0]        o_write_data,
    output logic [2:0]        o_load_status,
    output logic              o_last_of_run
);

    logic [CNT_W-1:0]  r_image_length;
    logic [CNT_W-1:0]  r_byte_count, n_byte_count;
    t_phase            r_phase, n_phase;
    logic [7:0]        r_sum, n_sum;
    t_status           r_fault, n_fault;
    logic [ADDR_W-1:0] r_load_base, n_load_base;
    logic [ADDR_W-1:0] r_size, n_size;
    logic [2:0]        r_vmask, n_vmask;
    logic [7:0]        r_vec [NUM_VEC];
    logic              vec_we;
    logic [VEC_IDX_W-1:0] vec_widx;

    logic [NUM_PEND-1:0] r_pend, n_pend;
    logic [ADDR_W-1:0]   r_wr_addr, n_wr_addr;
    logic [7:0]          r_wr_data, n_wr_data;
    t_status             r_status, n_status;

    logic                  in_xfer, out_xfer, last;
    logic [NUM_PEND-1:0]   cur_hot, rest;
    logic [PEND_IDX_W-1:0] cur_idx;
    logic [VEC_IDX_W-1:0]  vec_ridx;
    logic [3:0]            idx;
    logic [7:0]            b;
    logic [NUM_PEND-1:0]   fin_bits;
    logic [CNT_W-1:0]      count_inc, need_len, fit_sum;
    t_status               f15;

    // output selection
    always_comb begin
        cur_hot = r_pend & (~r_pend + NUM_PEND'(1));
        rest    = r_pend & ~cur_hot;
        last    = (rest == '0);
        cur_idx = '0;
        for (int i = NUM_PEND - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                cur_idx = PEND_IDX_W'(i);
            end
        end
        if (cur_idx == SLOT_WRITE || cur_idx == SLOT_STATUS) begin
            vec_ridx = '0;
        end else begin
            vec_ridx = VEC_IDX_W'(cur_idx - PEND_IDX_W'(1));
        end
    end

    always_comb begin
        o_out_valid     = |r_pend;
        o_last_of_run   = last;
        o_result_kind   = RK_WRITE;
        o_write_address = '0;
        o_write_data    = '0;
        o_load_status   = ST_OK;
        case (cur_idx)
            SLOT_WRITE: begin
                o_write_address = r_wr_addr;
                o_write_data    = r_wr_data;
            end
            SLOT_STATUS: begin
                o_result_kind = RK_STATUS;
                o_load_status = r_status;
            end
            default: begin
                o_write_address = VEC_BASE + ADDR_W'(vec_ridx);
                o_write_data    = r_vec[vec_ridx];
            end
        endcase
    end

    assign out_xfer   = o_out_valid && !i_out_stall;
    assign o_in_stall = o_out_valid && !(out_xfer && last);
    assign in_xfer    = i_in_valid && !o_in_stall;

    // next state
    always_comb begin
        b            = i_image_byte;
        idx          = r_byte_count[3:0];
        n_byte_count = r_byte_count;
        n_phase      = r_phase;
        n_sum        = r_sum;
        n_fault      = r_fault;
        n_load_base  = r_load_base;
        n_size       = r_size;
        n_vmask      = r_vmask;
        n_wr_addr    = r_wr_addr;
        n_wr_data    = r_wr_data;
        n_status     = r_status;
        vec_we       = 1'b0;
        vec_widx     = VEC_IDX_W'(idx - IDX_VEC0);
        f15          = r_fault;
        n_pend       = out_xfer ? rest : r_pend;

        count_inc = r_byte_count + CNT_W'(1);
        need_len  = CNT_W'(HDR_BYTES) + CNT_W'(r_size);
        fit_sum   = CNT_W'(r_load_base) + CNT_W'(r_size);
        fin_bits  = {1'b1, {2{r_vmask[2]}}, {2{r_vmask[1]}}, {2{r_vmask[0]}}, 1'b0};

        if (in_xfer) begin
            n_pend = '0;
            case (r_phase)
                PH_HEADER: begin
                    if (idx == IDX_START && r_image_length < CNT_W'(HDR_BYTES)) begin
                        n_pend[SLOT_STATUS] = 1'b1;
                        n_status            = ST_TOO_SMALL;
                        n_phase             = PH_DONE;
                    end else begin
                        n_byte_count = count_inc;
                        if (idx >= IDX_BASE_LO && idx <= IDX_VEC5) begin
                            n_sum = r_sum + b;
                        end
                        case (idx)
                            IDX_START: begin
                                if (b != START_MARK) begin
                                    n_fault = merge_fault(r_fault, ST_MARKERS);
                                end
                            end
                            IDX_MAJOR: begin
                                if (b != MAJOR_VER) begin
                                    n_fault = merge_fault(r_fault, ST_VERSION);
                                end
                            end
                            IDX_BASE_LO: n_load_base = {r_load_base[15:8], b};
                            IDX_BASE_HI: n_load_base = {b, r_load_base[7:0]};
                            IDX_SIZE_LO: n_size      = {r_size[15:8], b};
                            IDX_SIZE_HI: n_size      = {b, r_size[7:0]};
                            IDX_TYPE:    n_vmask     = b[2:0];
                            IDX_CSUM: begin
                                if (b != r_sum) begin
                                    n_fault = merge_fault(r_fault, ST_CHECKSUM);
                                end
                            end
                            IDX_END: begin
                                if (b != END_MARK) begin
                                    f15 = merge_fault(f15, ST_MARKERS);
                                end
                                if (fit_sum > MEM_TOP) begin
                                    f15 = merge_fault(f15, ST_NO_FIT);
                                end
                                if (r_image_length != need_len) begin
                                    f15 = merge_fault(f15, ST_SIZE);
                                end
                                n_fault = f15;
                                if (f15 != ST_OK) begin
                                    n_pend[SLOT_STATUS] = 1'b1;
                                    n_status            = f15;
                                    n_phase             = PH_DONE;
                                end else if (r_size == '0) begin
                                    n_pend   = fin_bits;
                                    n_status = ST_OK;
                                    n_phase  = PH_DONE;
                                end else begin
                                    n_phase = PH_PAYLOAD;
                                end
                            end
                            default: begin
                                if (idx >= IDX_VEC0 && idx <= IDX_VEC5) begin
                                    vec_we = 1'b1;
                                end
                            end
                        endcase
                    end
                end
                PH_PAYLOAD: begin
                    n_wr_addr    = r_load_base + r_byte_count[ADDR_W-1:0]
                                   - ADDR_W'(HDR_BYTES);
                    n_wr_data    = b;
                    n_byte_count = count_inc;
                    n_pend       = '0;
                    n_pend[SLOT_WRITE] = 1'b1;
                    if (count_inc >= need_len) begin
                        n_pend   = fin_bits;
                        n_pend[SLOT_WRITE] = 1'b1;
                        n_status = ST_OK;
                        n_phase  = PH_DONE;
                    end
                end
                default: begin
                    n_pend = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_length <= '0;
            r_byte_count   <= '0;
            r_phase        <= PH_HEADER;
            r_sum          <= '0;
            r_fault        <= ST_OK;
            r_pend         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_image_length <= i_cfg_wdata;
            end
            r_byte_count <= n_byte_count;
            r_phase      <= n_phase;
            r_sum        <= n_sum;
            r_fault      <= n_fault;
            r_pend       <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_load_base <= n_load_base;
        r_size      <= n_size;
        r_vmask     <= n_vmask;
        r_wr_addr   <= n_wr_addr;
        r_wr_data   <= n_wr_data;
        r_status    <= n_status;
        if (vec_we) begin
            r_vec[vec_widx] <= b;
        end
    end

endmodule

// ----- hdl/cil_checker.sv -----
module cil_checker
    import cil_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic              o_result_kind,
    input logic [ADDR_W-1:0] o_write_address,
    input logic [7:0]        o_write_data,
    input logic [2:0]        o_load_status,
    input logic              o_last_of_run
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output result dropped while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind |-> o_last_of_run
        && o_write_address == '0 && o_write_data == '0)
        else $error("status result malformed");

    a_write_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_result_kind |-> o_load_status == ST_OK)
        else $error("memory write carries a status");

endmodule

bind cartridge_image_loader cil_checker u_cil_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_result_kind   (o_result_kind),
    .o_write_address (o_write_address),
    .o_write_data    (o_write_data),
    .o_load_status   (o_load_status),
    .o_last_of_run   (o_last_of_run)
);

// ----- dv/cartridge_image_loader_tb.sv -----
`timescale 1ns / 1ps

module cartridge_image_loader_tb;
    import cil_pkg::*;

    localparam int unsigned PAYLOAD_LEN = 300;
    localparam logic [ADDR_W-1:0] LOAD_BASE = ADDR_W'(MEM_TOP - PAYLOAD_LEN);
    localparam int unsigned TRAILING_BYTES = 4;

    typedef struct {
        t_kind              kind;
        logic [ADDR_W-1:0]  addr;
        logic [7:0]         data;
        t_status            status;
        logic               last;
    } t_load_result;

    typedef struct {
        bit                 is_len;
        logic [CNT_W-1:0]   len;
        logic [7:0]         data;
        bit                 typed;
        t_load_result       want;
    } t_stim_row;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CNT_W-1:0]  cfg_wdata = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [7:0]        image_byte = 8'h00;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              result_kind;
    logic [ADDR_W-1:0] write_address;
    logic [7:0]        write_data;
    logic [2:0]        load_status;
    logic              last_of_run;

    int unsigned tx_idle_pct = 11;
    int unsigned rx_idle_pct = 75;
    bit          rx_hold = 1'b0;
    int unsigned failures = 0;

    t_load_result expected_results[$];
    t_load_result byte_results[$];
    t_stim_row    directed_rows[$];

    // loader state as seen from outside
    logic [CNT_W-1:0]  img_len = '0;
    logic [CNT_W-1:0]  img_count = '0;
    t_phase            img_phase = PH_HEADER;
    logic [7:0]        img_sum = 8'h00;
    logic [ADDR_W-1:0] img_base = '0;
    logic [15:0]       img_size = '0;
    logic [2:0]        img_mask = '0;
    logic [7:0]        img_vec [NUM_VEC];
    t_status           img_fault = ST_OK;

    cartridge_image_loader DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_image_byte    (image_byte),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_result_kind   (result_kind),
        .o_write_address (write_address),
        .o_write_data    (write_data),
        .o_load_status   (load_status),
        .o_last_of_run   (last_of_run)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic t_load_result write_result(input logic [ADDR_W-1:0] a,
                                                  input logic [7:0] d);
        t_load_result r;
        r.kind   = RK_WRITE;
        r.addr   = a;
        r.data   = d;
        r.status = ST_OK;
        r.last   = 1'b0;
        return r;
    endfunction

    function automatic t_load_result status_result(input t_status code);
        t_load_result r;
        r.kind   = RK_STATUS;
        r.addr   = '0;
        r.data   = 8'h00;
        r.status = code;
        r.last   = 1'b0;
        return r;
    endfunction

    function automatic t_stim_row blank_row();
        t_stim_row row;
        row.is_len = 1'b0;
        row.len    = '0;
        row.data   = 8'h00;
        row.typed  = 1'b0;
        row.want   = status_result(ST_OK);
        return row;
    endfunction

    // lowest nonzero code wins
    function automatic void note_fault(input t_status code);
        if (img_fault == ST_OK || code < img_fault) begin
            img_fault = code;
        end
    endfunction

    function automatic void close_load();
        for (int i = 0; i < 3; i++) begin
            if (img_mask[i]) begin
                byte_results.push_back(write_result(VEC_BASE + ADDR_W'(2 * i), img_vec[2 * i]));
                byte_results.push_back(write_result(VEC_BASE + ADDR_W'(2 * i + 1),
                                                    img_vec[2 * i + 1]));
            end
        end
        byte_results.push_back(status_result(ST_OK));
        img_phase = PH_DONE;
    endfunction

    task automatic predict_image_byte(input logic [7:0] b, input bit keep);
        logic [3:0] idx;
        idx = img_count[3:0];
        byte_results.delete();
        if (img_phase == PH_HEADER) begin
            if (img_count == 0 && img_len < HDR_BYTES) begin
                byte_results.push_back(status_result(ST_TOO_SMALL));
                img_phase = PH_DONE;
            end else begin
                case (idx)
                    IDX_START:   if (b != START_MARK) note_fault(ST_MARKERS);
                    IDX_MAJOR:   if (b != MAJOR_VER) note_fault(ST_VERSION);
                    IDX_BASE_LO: img_base[7:0] = b;
                    IDX_BASE_HI: img_base[15:8] = b;
                    IDX_SIZE_LO: img_size[7:0] = b;
                    IDX_SIZE_HI: img_size[15:8] = b;
                    IDX_TYPE:    img_mask = b[2:0];
                    IDX_CSUM:    if (img_sum != b) note_fault(ST_CHECKSUM);
                    IDX_END:     if (b != END_MARK) note_fault(ST_MARKERS);
                    default: begin
                        if (idx >= IDX_VEC0 && idx <= IDX_VEC5) begin
                            img_vec[VEC_IDX_W'(idx - IDX_VEC0)] = b;
                        end
                    end
                endcase
                if (idx >= IDX_BASE_LO && idx <= IDX_VEC5) begin
                    img_sum = img_sum + b;
                end
                img_count = img_count + 1'b1;
                if (idx == IDX_END) begin
                    if ({1'b0, img_base} + {1'b0, img_size} > MEM_TOP) begin
                        note_fault(ST_NO_FIT);
                    end
                    if (img_len != HDR_BYTES + img_size) begin
                        note_fault(ST_SIZE);
                    end
                    if (img_fault != ST_OK) begin
                        byte_results.push_back(status_result(img_fault));
                        img_phase = PH_DONE;
                    end else if (img_size == 0) begin
                        close_load();
                    end else begin
                        img_phase = PH_PAYLOAD;
                    end
                end
            end
        end else if (img_phase == PH_PAYLOAD) begin
            byte_results.push_back(write_result(img_base + ADDR_W'(img_count - HDR_BYTES), b));
            img_count = img_count + 1'b1;
            if (img_count >= HDR_BYTES + img_size) begin
                close_load();
            end
        end
        if (byte_results.size() > 0) begin
            byte_results[$].last = 1'b1;
            if (keep) begin
                foreach (byte_results[i]) expected_results.push_back(byte_results[i]);
            end
        end
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_image_byte(input logic [7:0] b, input bit keep);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        image_byte <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_image_byte(b, keep);
        @(negedge clk);
    endtask

    // only while nothing is in flight
    task automatic write_image_length(input logic [CNT_W-1:0] v);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        img_len = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic void add_len(input logic [CNT_W-1:0] v);
        t_stim_row row;
        row = blank_row();
        row.is_len = 1'b1;
        row.len    = v;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        t_stim_row row;
        row = blank_row();
        row.data = b;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_checked_byte(input logic [7:0] b, input logic [ADDR_W-1:0] a);
        t_stim_row row;
        row = blank_row();
        row.data      = b;
        row.typed     = 1'b1;
        row.want      = write_result(a, b);
        row.want.last = 1'b1;
        directed_rows.push_back(row);
    endfunction

    always @(negedge clk) begin
        out_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
    end

    always @(posedge clk) begin : result_check
        t_load_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("unexpected result: kind %0d addr %h data %h status %0d last %0d",
                             result_kind, write_address, write_data, load_status, last_of_run);
                end
            end else begin
                want = expected_results.pop_front();
                if (want.kind !== result_kind || want.addr !== write_address ||
                    want.data !== write_data || want.status !== load_status ||
                    want.last !== last_of_run) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("mismatch: want kind %0d addr %h data %h status %0d last %0d",
                                 want.kind, want.addr, want.data, want.status, want.last);
                        $display("          got  kind %0d addr %h data %h status %0d last %0d",
                                 result_kind, write_address, write_data, load_status,
                                 last_of_run);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        logic [7:0] hdr [HDR_BYTES];
        logic [7:0] sum;
        int unsigned n_random;
        foreach (img_vec[i]) img_vec[i] = 8'h00;

        // full fit: base + size lands exactly on the top of memory
        hdr = '{START_MARK, 8'hFF, MAJOR_VER, LOAD_BASE[7:0], LOAD_BASE[15:8],
                8'(PAYLOAD_LEN), 8'(PAYLOAD_LEN >> 8), 8'hFF,
                8'h00, 8'hFF, 8'h34, 8'h12, 8'h78, 8'h56, 8'h00, END_MARK};
        sum = 8'h00;
        for (int i = IDX_BASE_LO; i <= IDX_VEC5; i++) sum = sum + hdr[i];
        hdr[IDX_CSUM] = sum;

        // length is checked on the first byte and again on the end marker
        add_len({CNT_W{1'b1}});
        for (int i = 0; i < IDX_VEC0; i++) add_byte(hdr[i]);
        add_len('0);
        for (int i = IDX_VEC0; i < IDX_END; i++) add_byte(hdr[i]);
        add_len(CNT_W'(HDR_BYTES + PAYLOAD_LEN));
        add_byte(hdr[IDX_END]);
        add_checked_byte(8'h00, LOAD_BASE);
        add_checked_byte(8'hFF, LOAD_BASE + 1'b1);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_len) begin
                in_valid <= 1'b0;
                write_image_length(directed_rows[i].len);
            end else if (directed_rows[i].typed) begin
                expected_results.push_back(directed_rows[i].want);
                send_image_byte(directed_rows[i].data, 1'b0);
            end else begin
                send_image_byte(directed_rows[i].data, 1'b1);
            end
        end

        // rest of the payload, then bytes past the end that must be dropped
        n_random = PAYLOAD_LEN - 2 + TRAILING_BYTES;
        for (int unsigned i = 0; i < n_random; i++) begin
            if (i == n_random / 3) begin
                tx_idle_pct = 75;
                rx_idle_pct = 11;
            end else if (i == 2 * n_random / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                fork
                    begin
                        @(posedge clk);
                        rx_hold = 1'b1;
                        repeat (60) @(posedge clk);
                        rx_hold = 1'b0;
                    end
                join_none
            end
            send_image_byte(8'($urandom), 1'b1);
        end
        in_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (failures == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/cil_pkg.sv
hdl/cartridge_image_loader.sv
hdl/cil_checker.sv
dv/cartridge_image_loader_tb.sv
